[design/ipv4_udp_payload_filter_assert.svh]
// ----------------------------------------------------------------------------
// IPv4 UDP payload filter assertion macros
// Shared concurrent assertion forms for the filter, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef IPV4_UDP_PAYLOAD_FILTER_ASSERT_SVH
`define IPV4_UDP_PAYLOAD_FILTER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define IUF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("IUF assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define IUF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("IUF assertion failed");

`endif

[design/iuf_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 UDP payload filter package
// Payload types, header offsets and field constants of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iuf_pkg;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        frame_start;
    logic        frame_end;
    logic [15:0] captured_length;
  } iuf_in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       from_device;
    logic       payload_last;
  } iuf_out_t;

  localparam logic [15:0] OffEtherHi   = 16'd12;
  localparam logic [15:0] OffEtherLo   = 16'd13;
  localparam logic [15:0] OffVerIhl    = 16'd14;
  localparam logic [15:0] OffTotLenHi  = 16'd16;
  localparam logic [15:0] OffTotLenLo  = 16'd17;
  localparam logic [15:0] OffFlags     = 16'd20;
  localparam logic [15:0] OffFragLo    = 16'd21;
  localparam logic [15:0] OffProto     = 16'd23;
  localparam logic [15:0] OffSrcFirst  = 16'd26;
  localparam logic [15:0] OffSrcLast   = 16'd29;
  localparam logic [15:0] OffDstFirst  = 16'd30;
  localparam logic [15:0] OffDstLast   = 16'd33;
  localparam logic [15:0] OffVerdict   = 16'd33;
  localparam logic [15:0] OffPayload   = 16'd42;
  localparam logic [15:0] OffMax       = 16'hFFFF;

  localparam logic [7:0]  EtherTypeHi  = 8'h08;
  localparam logic [7:0]  EtherTypeLo  = 8'h00;
  localparam logic [7:0]  VerIhlIpv4   = 8'h45;
  localparam logic [7:0]  FlagsMask    = 8'h3F;
  localparam logic [7:0]  FragOffLo    = 8'h00;
  localparam logic [7:0]  ProtoUdp     = 8'h11;
  localparam logic [15:0] MinIpTotal   = 16'd29;
  localparam logic [16:0] EthHdrLen    = 17'd14;

  function automatic logic [7:0] addr_octet(input logic [31:0] addr, input logic [1:0] idx);
    logic [7:0] oct;
    case (idx)
      2'd0:    oct = addr[31:24];
      2'd1:    oct = addr[23:16];
      2'd2:    oct = addr[15:8];
      default: oct = addr[7:0];
    endcase
    return oct;
  endfunction

endpackage

[design/ipv4_udp_payload_filter.sv]
// ----------------------------------------------------------------------------
// IPv4 UDP payload filter
// Checks the Ethernet, IPv4 and UDP headers of a byte stream and passes on
// the UDP payload of frames that involve the configured device address.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake         Transaction
//  in       input      valid / stall     one frame byte with framing marks
//  out      output     valid / stall     one payload byte with flags
//  cfg      input      valid / ready     device address write
//
// One byte is taken every cycle while the input is not stalled. A byte
// taken sits in the input register, and its result is loaded from there into
// the result register, which drives the output.
// Reset clears the address, the frame state and both valid flags.
// A stall on a valid output holds the result register and, once the input
// register is also full, stalls the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ipv4_udp_payload_filter_assert.svh"

module ipv4_udp_payload_filter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  iuf_pkg::iuf_in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output iuf_pkg::iuf_out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [31:0]    cfg_data_i
);
  import iuf_pkg::*;

  logic        in_valid_q, in_valid_d;
  iuf_in_t     in_q;
  logic        out_valid_q, out_valid_d;
  iuf_out_t    out_q, out_d;
  logic [31:0] dev_addr_q;
  logic [15:0] byte_offset_q, byte_offset_d;
  logic        frame_ok_q, frame_ok_d;
  logic [15:0] tot_len_q, tot_len_d;
  logic        src_match_q, src_match_d;
  logic        dst_match_q, dst_match_d;
  logic [15:0] len_q, len_d;

  logic        out_free;
  logic        consume;
  logic        res_valid;
  logic [15:0] off;
  logic        ok;
  logic [7:0]  b;
  logic [7:0]  dev_oct;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign consume     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_valid_d  = in_stall_o ? in_valid_q : in_valid_i;

  assign b       = in_q.frame_byte;
  assign off     = in_q.frame_start ? 16'd0 : byte_offset_q;
  assign dev_oct = addr_octet(dev_addr_q, off[1:0] + 2'd2);

  always_comb begin
    ok          = in_q.frame_start ? 1'b1 : frame_ok_q;
    len_d       = in_q.frame_start ? in_q.captured_length : len_q;
    tot_len_d   = in_q.frame_start ? 16'd0 : tot_len_q;
    src_match_d = in_q.frame_start ? 1'b1 : src_match_q;
    dst_match_d = in_q.frame_start ? 1'b1 : dst_match_q;
    res_valid   = 1'b0;

    if (off >= len_d) begin
      ok = 1'b0;
    end

    if (ok) begin
      case (off)
        OffEtherHi:  if (b != EtherTypeHi) ok = 1'b0;
        OffEtherLo:  if (b != EtherTypeLo) ok = 1'b0;
        OffVerIhl:   if (b != VerIhlIpv4) ok = 1'b0;
        OffTotLenHi: tot_len_d = {b, 8'h00};
        OffTotLenLo: tot_len_d = {tot_len_d[15:8], b};
        OffFlags:    if ((b & FlagsMask) != 8'h00) ok = 1'b0;
        OffFragLo:   if (b != FragOffLo) ok = 1'b0;
        OffProto:    if (b != ProtoUdp) ok = 1'b0;
        default: begin
        end
      endcase
      if ((off inside {[OffSrcFirst:OffSrcLast]}) && b != dev_oct) begin
        src_match_d = 1'b0;
      end
      if ((off inside {[OffDstFirst:OffDstLast]}) && b != dev_oct) begin
        dst_match_d = 1'b0;
      end
      if (off == OffVerdict) begin
        if (tot_len_d < MinIpTotal ||
            ({1'b0, tot_len_d} + EthHdrLen) > {1'b0, len_d} ||
            !(src_match_d || dst_match_d)) begin
          ok = 1'b0;
        end
      end
      res_valid = ok && (off >= OffPayload);
    end

    out_d.payload_byte = b;
    out_d.from_device  = src_match_d;
    out_d.payload_last = in_q.frame_end || ((off + 16'd1) == len_d);

    frame_ok_d    = ok && !in_q.frame_end;
    byte_offset_d = (off != OffMax) ? off + 16'd1 : off;
    out_valid_d   = consume ? res_valid : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      dev_addr_q    <= 32'd0;
      byte_offset_q <= 16'd0;
      frame_ok_q    <= 1'b0;
      tot_len_q     <= 16'd0;
      src_match_q   <= 1'b0;
      dst_match_q   <= 1'b0;
      len_q         <= 16'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dev_addr_q <= cfg_data_i;
      end
      if (consume) begin
        byte_offset_q <= byte_offset_d;
        frame_ok_q    <= frame_ok_d;
        tot_len_q     <= tot_len_d;
        src_match_q   <= src_match_d;
        dst_match_q   <= dst_match_d;
        len_q         <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (consume) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `IUF_ASSERT_NOW(a_res_after_header, clk_i, rst_ni, consume && res_valid, off >= OffPayload)
  `IUF_ASSERT_NEXT(a_end_closes_frame, clk_i, rst_ni, consume && in_q.frame_end, !frame_ok_q)
  `IUF_ASSERT_NEXT(a_stage_holds, clk_i, rst_ni, in_stall_o, in_valid_q && $stable(in_q))
  `IUF_ASSERT_NEXT(a_offset_counts, clk_i, rst_ni,
                   consume && !in_q.frame_start && byte_offset_q != OffMax,
                   byte_offset_q == $past(byte_offset_q) + 16'd1)

endmodule

[bench/tb_ipv4_udp_payload_filter.sv]
// ----------------------------------------------------------------------------
// IPv4 UDP payload filter testbench
// Sends Ethernet frames through the filter byte by byte, with random gaps and
// receiver stalls. The bench predicts each payload byte on its own and checks
// every output transaction against the oldest prediction, over several device
// addresses and both well-formed and broken frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ipv4_udp_payload_filter;
  import iuf_pkg::*;

  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 400;
  localparam int IdlePercent = 37;

  typedef enum int {
    BadNone, BadEtherHi, BadEtherLo, BadVerIhl, BadFlags, BadFrag, BadProto
  } hdr_fault_e;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  iuf_in_t     in_data   = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  iuf_out_t    out_data_o;
  logic        cfg_ready_o;

  logic        quiet     = 1'b0;
  logic        hold_go   = 1'b0;
  logic        holding   = 1'b0;

  iuf_in_t     frame_bytes_q[$];
  iuf_out_t    payload_due[$];

  // Filter state as the bench tracks it.
  logic [31:0] watch_addr = '0;
  logic [15:0] pos        = '0;
  logic        viable     = 1'b0;
  logic [15:0] tot_len    = '0;
  logic        src_hit    = 1'b0;
  logic        dst_hit    = 1'b0;
  logic [15:0] cap_len    = '0;

  logic [31:0] dev;
  int          err_count       = 0;
  int          n_frames        = 0;
  int          bytes_taken     = 0;
  int          payload_checked = 0;
  int          n_settings      = 0;

  ipv4_udp_payload_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("Timeout with %0d payload bytes still due", payload_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    wait (hold_go);
    @(negedge clk_i);
    holding = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    holding = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Works out the payload transaction, if any, that one accepted frame byte causes.
  task automatic filter_byte(input iuf_in_t it);
    int       k;
    logic     last;
    iuf_out_t res;
    if (it.frame_start) begin
      pos     = '0;
      viable  = 1'b1;
      tot_len = '0;
      src_hit = 1'b1;
      dst_hit = 1'b1;
      cap_len = it.captured_length;
    end
    if (viable && pos >= cap_len) viable = 1'b0;
    if (viable) begin
      case (pos)
        OffEtherHi:  if (it.frame_byte != EtherTypeHi) viable = 1'b0;
        OffEtherLo:  if (it.frame_byte != EtherTypeLo) viable = 1'b0;
        OffVerIhl:   if (it.frame_byte != VerIhlIpv4) viable = 1'b0;
        OffTotLenHi: tot_len = {it.frame_byte, 8'h00};
        OffTotLenLo: tot_len[7:0] = it.frame_byte;
        OffFlags:    if ((it.frame_byte & FlagsMask) != 8'h00) viable = 1'b0;
        OffFragLo:   if (it.frame_byte != FragOffLo) viable = 1'b0;
        OffProto:    if (it.frame_byte != ProtoUdp) viable = 1'b0;
        default: ;
      endcase
      if (pos >= OffSrcFirst && pos <= OffSrcLast) begin
        k = int'(pos - OffSrcFirst);
        if (it.frame_byte != watch_addr[31 - 8 * k -: 8]) src_hit = 1'b0;
      end
      if (pos >= OffDstFirst && pos <= OffDstLast) begin
        k = int'(pos - OffDstFirst);
        if (it.frame_byte != watch_addr[31 - 8 * k -: 8]) dst_hit = 1'b0;
      end
      if (pos == OffVerdict) begin
        if (tot_len < MinIpTotal || {1'b0, tot_len} + EthHdrLen > {1'b0, cap_len} ||
            !(src_hit || dst_hit)) begin
          viable = 1'b0;
        end
      end
      if (viable && pos >= OffPayload) begin
        last = it.frame_end || ({1'b0, pos} + 17'd1 == {1'b0, cap_len});
        res.payload_byte = it.frame_byte;
        res.from_device  = src_hit;
        res.payload_last = last;
        payload_due.push_back(res);
      end
    end
    if (it.frame_end) viable = 1'b0;
    if (pos != OffMax) pos = pos + 16'd1;
  endtask

  task automatic check_payload(input iuf_out_t got);
    iuf_out_t want;
    if (payload_due.size() == 0) begin
      report_mismatch($sformatf("payload byte %02h arrived with none due", got.payload_byte));
    end else begin
      want = payload_due.pop_front();
      payload_checked++;
      if (got.payload_byte != want.payload_byte)
        report_mismatch($sformatf("payload_byte %02h, predicted %02h",
                                  got.payload_byte, want.payload_byte));
      if (got.from_device != want.from_device)
        report_mismatch($sformatf("from_device %0b, predicted %0b",
                                  got.from_device, want.from_device));
      if (got.payload_last != want.payload_last)
        report_mismatch($sformatf("payload_last %0b, predicted %0b",
                                  got.payload_last, want.payload_last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        filter_byte(in_data);
        bytes_taken++;
      end
      if (!in_valid || !in_stall_o) begin
        if (frame_bytes_q.size() != 0 && (quiet || $urandom_range(99) >= IdlePercent)) begin
          in_valid <= 1'b1;
          in_data  <= frame_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) check_payload(out_data_o);
      out_stall <= holding || (!quiet && $urandom_range(99) < IdlePercent);
    end
  end

  function automatic logic [31:0] other_addr(input logic [31:0] a);
    return a ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
  endfunction

  task automatic write_address(input logic [31:0] a);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid  <= 1'b0;
    watch_addr = a;
    dev        = a;
    n_settings++;
  endtask

  task automatic queue_frame(input int caplen, input int nbytes, input int tl,
                             input logic [31:0] src_a, input logic [31:0] dst_a,
                             input hdr_fault_e fault, input bit with_end,
                             input bit noisy_len);
    logic [15:0] tl16;
    logic [7:0]  b;
    iuf_in_t     it;
    tl16 = 16'(tl);
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      case (i)
        12: b = (fault == BadEtherHi) ? EtherTypeHi ^ 8'($urandom_range(1, 255)) : EtherTypeHi;
        13: b = (fault == BadEtherLo) ? EtherTypeLo ^ 8'($urandom_range(1, 255)) : EtherTypeLo;
        14: b = (fault == BadVerIhl) ? VerIhlIpv4 ^ 8'($urandom_range(1, 255)) : VerIhlIpv4;
        16: b = tl16[15:8];
        17: b = tl16[7:0];
        20: b = {b[7:6], (fault == BadFlags) ? 6'($urandom_range(1, 63)) : 6'd0};
        21: b = (fault == BadFrag) ? FragOffLo ^ 8'($urandom_range(1, 255)) : FragOffLo;
        23: b = (fault == BadProto) ? ProtoUdp ^ 8'($urandom_range(1, 255)) : ProtoUdp;
        26, 27, 28, 29: b = src_a[31 - 8 * (i - 26) -: 8];
        30, 31, 32, 33: b = dst_a[31 - 8 * (i - 30) -: 8];
        default: ;
      endcase
      it.frame_byte      = b;
      it.frame_start     = (i == 0);
      it.frame_end       = with_end && (i == nbytes - 1);
      it.captured_length = (i == 0 || !noisy_len) ? 16'(caplen) : 16'($urandom_range(0, 65535));
      frame_bytes_q.push_back(it);
    end
    n_frames++;
  endtask

  task automatic queue_stray(input int n);
    iuf_in_t it;
    for (int i = 0; i < n; i++) begin
      it.frame_byte      = 8'($urandom);
      it.frame_start     = 1'b0;
      it.frame_end       = 1'($urandom);
      it.captured_length = 16'($urandom);
      frame_bytes_q.push_back(it);
    end
  endtask

  task automatic random_frame();
    int          caplen, nbytes, tl, pick;
    logic [31:0] src_a, dst_a;
    hdr_fault_e  fault;
    bit          with_end;
    caplen   = $urandom_range(43, 70);
    nbytes   = caplen;
    tl       = $urandom_range(29, caplen - 14);
    fault    = BadNone;
    with_end = 1'b1;
    pick     = $urandom_range(2);
    src_a    = (pick != 1) ? dev : other_addr(dev);
    dst_a    = (pick != 0) ? dev : other_addr(dev);
    if ($urandom_range(99) < 70) begin
      case ($urandom_range(9))
        0: nbytes = caplen + $urandom_range(1, 6);
        1: nbytes = $urandom_range(43, caplen);
        2: begin
          caplen = $urandom_range(100, 65535);
          nbytes = $urandom_range(43, 80);
          tl     = $urandom_range(29, nbytes - 14);
        end
        default: ;
      endcase
    end else begin
      case ($urandom_range(6))
        0: fault = hdr_fault_e'($urandom_range(1, 6));
        1: begin
          src_a = other_addr(dev);
          dst_a = other_addr(dev);
        end
        2: tl = $urandom_range(0, 28);
        3: tl = $urandom_range(caplen - 13, 65535);
        4: nbytes = $urandom_range(1, 33);
        5: begin
          nbytes   = $urandom_range(10, caplen);
          with_end = 1'b0;
        end
        default: queue_stray($urandom_range(1, 8));
      endcase
    end
    queue_frame(caplen, nbytes, tl, src_a, dst_a, fault, with_end, 1'($urandom));
  endtask

  task automatic random_phase(input int n_bytes);
    int target;
    target = frame_bytes_q.size() + n_bytes;
    while (frame_bytes_q.size() < target) random_frame();
  endtask

  task automatic drain();
    while (frame_bytes_q.size() != 0 || in_valid || payload_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic directed_frames();
    logic [31:0] oth;
    oth = dev ^ 32'h0000_00FF;
    queue_stray(3);
    queue_frame(50, 50, 36, dev, oth, BadNone, 1, 0);
    queue_frame(45, 45, 31, oth, dev, BadNone, 1, 0);
    queue_frame(48, 48, 30, dev, dev, BadNone, 1, 0);
    queue_frame(48, 48, 30, oth, dev ^ 32'hFF00_0000, BadNone, 1, 0);
    queue_frame(48, 48, 28, dev, oth, BadNone, 1, 0);
    queue_frame(43, 43, 29, dev, oth, BadNone, 1, 0);
    queue_frame(48, 48, 35, dev, oth, BadNone, 1, 0);
    for (int f = BadEtherHi; f <= BadProto; f++)
      queue_frame(46, 46, 32, dev, oth, hdr_fault_e'(f), 1, 0);
    queue_frame(60, 21, 40, dev, oth, BadNone, 1, 0);
    queue_frame(60, 34, 40, dev, oth, BadNone, 1, 0);
    queue_frame(60, 30, 40, dev, oth, BadNone, 0, 0);
    queue_frame(47, 47, 33, oth, dev, BadNone, 1, 0);
    queue_frame(65535, 60, 46, dev, oth, BadNone, 1, 1);
    queue_frame(45, 50, 31, oth, dev, BadNone, 1, 1);
    queue_frame(30, 50, 29, dev, oth, BadNone, 1, 0);
    queue_frame(1, 1, 29, dev, oth, BadNone, 1, 0);
    queue_frame(0, 44, 29, dev, oth, BadNone, 1, 0);
    queue_stray(2);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_address(32'hC0A8_0102);
    @(negedge clk_i);
    directed_frames();
    drain();

    write_address(32'h0000_0000);
    @(negedge clk_i);
    random_phase(100);
    drain();

    write_address(32'hFFFF_FFFF);
    @(negedge clk_i);
    hold_go = 1'b1;
    random_phase(100);
    drain();

    write_address($urandom);
    @(negedge clk_i);
    quiet = 1'b1;
    random_phase(80);
    drain();
    quiet = 1'b0;

    write_address($urandom);
    @(negedge clk_i);
    random_phase(80);
    drain();

    if (payload_due.size() != 0)
      report_mismatch($sformatf("%0d payload bytes never arrived", payload_due.size()));
    $display("Run covered %0d frames and %0d bytes under %0d device addresses.",
             n_frames, bytes_taken, n_settings);
    $display("%0d payload transactions were checked, with a long receiver hold-off.",
             payload_checked);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
